### design/qvd_pkg.sv
// Package for the quantized vertex dedup block: widths, hash constant and defaults.
// No dependencies; used by the interfaces, the top level and the quantizer.
package qvd_pkg;

    localparam int FIELD_BITS = 21;
    localparam int KEY_W      = 3 * FIELD_BITS;
    localparam int VIDX_W     = 12;
    localparam int EPOCH_W    = 8;
    localparam int SHIFT_W    = 5;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam int HASH_SLOTS_DEF = 8192;
    localparam int MAX_UNIQUE_DEF = 4096;
    localparam int COORD_BITS_DEF = 32;

    localparam logic REG_QUANT_SHIFT = 1'b0;

endpackage

### design/qvd_vtx_if.sv
// Input channel: one vertex word (mesh start flag and three coordinates).
// Depends on qvd_pkg for the default coordinate width.
interface qvd_vtx_if #(
    parameter int COORD_BITS = qvd_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         first_of_mesh;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;

    modport source (output valid, first_of_mesh, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, first_of_mesh, pos_x, pos_y, pos_z, output ready);
endinterface

### design/qvd_res_if.sv
// Output channel: one result word (vertex index, new flag, overflow flag).
// Depends on qvd_pkg for the index width.
interface qvd_res_if;
    import qvd_pkg::*;

    logic              valid;
    logic              ready;
    logic [VIDX_W-1:0] vertex_index;
    logic              is_new;
    logic              overflow;

    modport source (output valid, vertex_index, is_new, overflow, input ready);
    modport sink   (input valid, vertex_index, is_new, overflow, output ready);
endinterface

### design/quantized_vertex_dedup.sv
// Quantized vertex dedup top level: quantizer, shared 32x32 hash multiplier, probe sequencer.
// Flow: quantize the three coordinates, hash on the shared multiplier (then a remainder step
// on the same multiplier if HASH_SLOTS is not a power of two), read and check each probed
// slot, then load the output register; one word at a time, accepted only in idle.
// Reset: synchronous active low, then a clearing pass over all HASH_SLOTS slots with ready low.
// A mesh start word costs another clearing pass once every 255 meshes (epoch wrap).
module quantized_vertex_dedup #(
    parameter int HASH_SLOTS = qvd_pkg::HASH_SLOTS_DEF,
    parameter int MAX_UNIQUE = qvd_pkg::MAX_UNIQUE_DEF,
    parameter int COORD_BITS = qvd_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    qvd_vtx_if.sink                    i_vtx,
    qvd_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qvd_pkg::APB_AW-1:0] paddr,
    input  logic [qvd_pkg::APB_DW-1:0] pwdata,
    output logic [qvd_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import qvd_pkg::*;

    localparam int SLOT_AW = $clog2(HASH_SLOTS);
    localparam int CNT_W   = $clog2(MAX_UNIQUE + 1);
    localparam int WORD_W  = EPOCH_W + VIDX_W + KEY_W;
    localparam bit HASH_POW2 = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;

    localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(HASH_SLOTS - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(MAX_UNIQUE);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // reciprocal for an exact 32-bit divide by HASH_SLOTS
    localparam logic [63:0] MOD_MAGIC_W = (((64'd1 << SLOT_AW) - 64'(HASH_SLOTS)) << 32)
                                          / 64'(HASH_SLOTS) + 64'd1;
    localparam logic [31:0] MOD_MAGIC   = MOD_MAGIC_W[31:0];
    localparam logic [31:0] MOD_DIV     = 32'(HASH_SLOTS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_QNT  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_MOD  = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DLV  = 4'd7;

    localparam logic [4:0] STEP_QNT_LAST = 5'd2;
    localparam logic [4:0] STEP_MUL_LAST = 5'd3;
    localparam logic [4:0] STEP_MOD_LAST = 5'd3;

    typedef struct packed {
        logic [VIDX_W-1:0] vidx;
        logic              is_new;
        logic              overflow;
    } t_result;

    // control
    logic [3:0]         r_state, n_state;
    logic [4:0]         r_step, n_step;
    logic [SLOT_AW-1:0] r_clr_addr, n_clr_addr;
    logic               r_resume, n_resume;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SHIFT_W-1:0] r_qshift, n_qshift;
    logic               r_ovld, n_ovld;
    // payload
    logic [COORD_BITS-1:0] r_px, n_px, r_py, n_py, r_pz, n_pz;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [63:0]           r_prod, n_prod;
    logic [31:0]           r_acc, n_acc;
    logic [SLOT_AW-1:0]    r_pos, n_pos;
    logic [SLOT_AW-1:0]    r_probe, n_probe;
    t_result               r_res, n_res;
    t_result               r_out, n_out;

    logic [COORD_BITS-1:0] q_coord;
    logic [FIELD_BITS-1:0] q_val;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic [31:0]           mod_t1, mod_q, mod_rem;
    logic [SLOT_AW-1:0]    pos_next;

    logic               ram_we, ram_re;
    logic [SLOT_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata, ram_rdata;

    logic [EPOCH_W-1:0]      rd_epoch;
    logic [VIDX_W-1:0]       rd_vidx;
    logic [KEY_W-1:0]        rd_key;
    logic [CNT_W+VIDX_W-1:0] cnt_ext;
    logic [VIDX_W-1:0]       cnt_vidx;
    logic                    in_acc, out_acc, cfg_wr;

    qvd_quant #(.COORD_BITS(COORD_BITS)) u_quant (
        .i_coord (q_coord),
        .i_shift (r_qshift),
        .o_q     (q_val)
    );

    qvd_ram #(.WIDTH(WORD_W), .DEPTH(HASH_SLOTS)) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    assign in_acc  = i_vtx.valid && i_vtx.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_QUANT_SHIFT);

    assign i_vtx.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_ovld;
    assign o_res.vertex_index = r_out.vidx;
    assign o_res.is_new       = r_out.is_new;
    assign o_res.overflow     = r_out.overflow;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUANT_SHIFT) ? {{(APB_DW-SHIFT_W){1'b0}}, r_qshift}
                                                  : {APB_DW{1'b0}};

    assign rd_epoch = ram_rdata[WORD_W-1 -: EPOCH_W];
    assign rd_vidx  = ram_rdata[KEY_W +: VIDX_W];
    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign cnt_ext  = (CNT_W + VIDX_W)'(r_count);
    assign cnt_vidx = cnt_ext[VIDX_W-1:0];
    assign pos_next = (r_pos == SLOT_LAST) ? '0 : r_pos + 1'b1;
    assign mul_p    = mul_a * mul_b;
    // quotient from the reciprocal product, then remainder from quotient * HASH_SLOTS
    assign mod_t1   = r_prod[63:32];
    assign mod_q    = (mod_t1 + ((r_acc - mod_t1) >> 1)) >> (SLOT_AW - 1);
    assign mod_rem  = r_acc - r_prod[31:0];

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    q_coord = r_px;
            2'd1:    q_coord = r_py;
            default: q_coord = r_pz;
        endcase
        if (r_state == S_MOD) begin
            mul_a = (r_step == 5'd0) ? r_acc : r_prod[31:0];
            mul_b = (r_step == 5'd0) ? MOD_MAGIC : MOD_DIV;
        end else begin
            // bits 63:32 of key * HASH_MULT, from three partial products
            unique case (r_step[1:0])
                2'd0:    begin mul_a = r_key[31:0]; mul_b = HASH_MULT[31:0]; end
                2'd1:    begin mul_a = r_key[31:0]; mul_b = HASH_MULT[63:32]; end
                default: begin mul_a = {1'b0, r_key[KEY_W-1:32]}; mul_b = HASH_MULT[31:0]; end
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_clr_addr = r_clr_addr;
        n_resume   = r_resume;
        n_epoch    = r_epoch;
        n_count    = r_count;
        n_qshift   = r_qshift;
        n_ovld     = r_ovld;
        n_px       = r_px;
        n_py       = r_py;
        n_pz       = r_pz;
        n_key      = r_key;
        n_prod     = r_prod;
        n_acc      = r_acc;
        n_pos      = r_pos;
        n_probe    = r_probe;
        n_res      = r_res;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = {r_epoch, cnt_vidx, r_key};

        if (cfg_wr) begin
            n_qshift = pwdata[SHIFT_W-1:0];
        end
        if (out_acc) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == SLOT_LAST) begin
                    n_clr_addr = '0;
                    n_resume   = 1'b0;
                    n_state    = r_resume ? S_QNT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_px    = i_vtx.pos_x;
                    n_py    = i_vtx.pos_y;
                    n_pz    = i_vtx.pos_z;
                    n_step  = '0;
                    n_state = S_QNT;
                    if (i_vtx.first_of_mesh) begin
                        n_count = '0;
                        if (r_epoch == EPOCH_MAX) begin
                            n_epoch    = EPOCH_ONE;
                            n_clr_addr = '0;
                            n_resume   = 1'b1;
                            n_state    = S_CLR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end
                end
            end
            S_QNT: begin
                n_key  = {q_val, r_key[KEY_W-1:FIELD_BITS]};
                n_step = r_step + 1'b1;
                if (r_step == STEP_QNT_LAST) begin
                    n_step  = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = mul_p;
                n_step = r_step + 1'b1;
                if (r_step == 5'd1) begin
                    n_acc = r_prod[63:32];
                end else if (r_step != 5'd0) begin
                    n_acc = r_acc + r_prod[31:0];
                end
                if (r_step == STEP_MUL_LAST) begin
                    n_step  = '0;
                    n_probe = '0;
                    n_pos   = n_acc[SLOT_AW-1:0];
                    n_state = HASH_POW2 ? S_RD : S_MOD;
                end
            end
            S_MOD: begin
                n_step = r_step + 1'b1;
                if (r_step == 5'd1) begin
                    n_prod = {32'd0, mod_q};
                end else begin
                    n_prod = mul_p;
                end
                if (r_step == STEP_MOD_LAST) begin
                    n_step  = '0;
                    n_pos   = mod_rem[SLOT_AW-1:0];
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (rd_epoch != r_epoch) begin
                    n_state = S_DLV;
                    if (r_count >= CNT_MAX) begin
                        n_res = '{vidx: '0, is_new: 1'b0, overflow: 1'b1};
                    end else begin
                        ram_we  = 1'b1;
                        n_res   = '{vidx: cnt_vidx, is_new: 1'b1, overflow: 1'b0};
                        n_count = r_count + 1'b1;
                    end
                end else if (rd_key == r_key) begin
                    n_res   = '{vidx: rd_vidx, is_new: 1'b0, overflow: 1'b0};
                    n_state = S_DLV;
                end else if (r_probe == SLOT_LAST) begin
                    n_res   = '{vidx: '0, is_new: 1'b0, overflow: 1'b1};
                    n_state = S_DLV;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_pos   = pos_next;
                    n_state = S_RD;
                end
            end
            S_DLV: begin
                if (!r_ovld || o_res.ready) begin
                    n_out   = r_res;
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_step     <= '0;
            r_clr_addr <= '0;
            r_resume   <= 1'b0;
            r_epoch    <= EPOCH_ONE;
            r_count    <= '0;
            r_qshift   <= '0;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_clr_addr <= n_clr_addr;
            r_resume   <= n_resume;
            r_epoch    <= n_epoch;
            r_count    <= n_count;
            r_qshift   <= n_qshift;
            r_ovld     <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px    <= n_px;
        r_py    <= n_py;
        r_pz    <= n_pz;
        r_key   <= n_key;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_pos   <= n_pos;
        r_probe <= n_probe;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // epoch 0 marks a cleared slot, so the live epoch never takes it
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("live epoch is zero");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("unique count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != $past(r_count)) |-> $past(r_state) == S_CHK)
        else $error("unique count moved outside slot check");

    a_ovf_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.overflow) |-> (o_res.vertex_index == '0 && !o_res.is_new))
        else $error("overflow word with index or new flag");

    a_ready_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!i_vtx.ready && !ram_re))
        else $error("slot read or input taken during clearing pass");
endmodule

### design/qvd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module qvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/qvd_quant.sv
// Coordinate quantizer: arithmetic shift with truncation toward zero, low 21 bits kept.
// Depends on qvd_pkg for field and shift widths.
module qvd_quant #(
    parameter int COORD_BITS = qvd_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]       i_coord,
    input  logic [qvd_pkg::SHIFT_W-1:0] i_shift,
    output logic [qvd_pkg::FIELD_BITS-1:0] o_q
);
    import qvd_pkg::*;

    logic [COORD_BITS-1:0] shifted;
    logic [COORD_BITS-1:0] lost_mask;
    logic                  corr;

    always_comb begin
        shifted   = COORD_BITS'($signed(i_coord) >>> i_shift);
        lost_mask = ~({COORD_BITS{1'b1}} << i_shift);
        // negative value with dropped bits: floor -> toward zero
        corr      = i_coord[COORD_BITS-1] & (|(i_coord & lost_mask));
        o_q       = shifted[FIELD_BITS-1:0] + {{(FIELD_BITS-1){1'b0}}, corr};
    end
endmodule
